/* rtl/euclidean_distance_macros.svh */
// Assertion macros used by the checker file.
`ifndef EUCLIDEAN_DISTANCE_MACROS_SVH
`define EUCLIDEAN_DISTANCE_MACROS_SVH

// Concurrent assertion on the rising clock, held off while reset is asserted.
`define ED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define ED_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/ed_pkg.sv */
`timescale 1ns / 1ps

package ed_pkg;

    localparam int ELEM_WIDTH = 16;
    localparam int SQ_W       = 2 * ELEM_WIDTH;
    localparam int SUM_W      = 44;
    localparam int DIST_W     = SUM_W / 2;
    localparam int REM_W      = DIST_W + 1;
    localparam int STEP_W     = $clog2(DIST_W);

    localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(DIST_W - 1);

    // Control from the sequencer to the accumulator
    typedef struct packed {
        logic load;   // register the square of a newly transferred pair
        logic add;    // add the registered square into the sum
        logic clear;  // restart the sum for the next vector
    } acc_ctrl_t;

endpackage

/* rtl/ed_accum.sv */
`timescale 1ns / 1ps

module ed_accum
    import ed_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  acc_ctrl_t                    ctrl,
    input  logic signed [ELEM_WIDTH-1:0] elem_a,
    input  logic signed [ELEM_WIDTH-1:0] elem_b,
    output logic        [SUM_W-1:0]      sum,
    output logic                         overflowed
);

    logic signed [ELEM_WIDTH:0] diff;
    logic        [ELEM_WIDTH:0] mag_full;
    logic [ELEM_WIDTH-1:0]      mag;
    logic [SQ_W-1:0]            sq_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           sum_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic [SUM_W:0]             sum_wide;

    // |a - b| never exceeds 2^16 - 1, so its square fits 32 bits
    assign diff     = {elem_a[ELEM_WIDTH-1], elem_a} - {elem_b[ELEM_WIDTH-1], elem_b};
    assign mag_full = diff[ELEM_WIDTH] ? (~diff + 1'b1) : diff;
    assign mag      = mag_full[ELEM_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sq_reg <= SQ_W'(mag) * SQ_W'(mag);
        end
    end

    assign sum_wide = {1'b0, sum_reg} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_reg};

    always_comb
    begin
        sum_next = sum_reg;
        ovf_next = ovf_reg;
        if (ctrl.clear)
        begin
            sum_next = '0;
            ovf_next = 1'b0;
        end
        else if (ctrl.add)
        begin
            // saturate on carry out of the sum
            if (sum_wide[SUM_W])
            begin
                sum_next = SUM_MAX;
                ovf_next = 1'b1;
            end
            else
            begin
                sum_next = sum_wide[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
        end
    end

    assign sum        = sum_reg;
    assign overflowed = ovf_reg;

endmodule

/* rtl/ed_sqrt.sv */
`timescale 1ns / 1ps

module ed_sqrt
    import ed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  radicand,
    output logic              busy,
    output logic [DIST_W-1:0] root
);

    logic [SUM_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIST_W-1:0] root_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;

    logic [REM_W+1:0]  rem_shift;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  rem_diff;
    logic              fits;

    // One result bit per cycle: bring down two radicand bits, try 4*root + 1
    assign rem_shift = {rem_reg, rad_reg[SUM_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);
    assign rem_diff  = rem_shift - trial;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= fits ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
            root_reg <= {root_reg[DIST_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= LAST_STEP;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

/* rtl/euclidean_distance.sv */
// Flow: a pair without tlast has its square added in the ADD state, after which
// s_tready is high again; a pair with tlast then passes START and ROOT, and its
// distance is loaded into the output once the root is done and m_tvalid is low.
// No pair is taken until then; the 22-step root unit makes one bit per cycle.
// Reset: rst_n is asynchronous and active low; it clears the sum, the sticky
// saturation flag, the sequencer and the output valid.
`timescale 1ns / 1ps

module euclidean_distance
    import ed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] elem_a, [31:16] elem_b
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [21:0] distance, [23:22] zero
    output logic        m_tuser    // saturated
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ADD   = 2'd1;
    localparam logic [1:0] ST_START = 2'd2;
    localparam logic [1:0] ST_ROOT  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic              last_reg;
    logic              sat_reg;
    logic              out_valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              out_sat_reg;

    logic              accept;
    logic              load_out;
    acc_ctrl_t         acc_ctrl;
    logic [SUM_W-1:0]  sum;
    logic              overflowed;
    logic              root_busy;
    logic [DIST_W-1:0] root;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_ROOT) && !root_busy && !out_valid_reg;

    assign acc_ctrl.load  = accept;
    assign acc_ctrl.add   = (state_reg == ST_ADD);
    assign acc_ctrl.clear = (state_reg == ST_START);

    ed_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (acc_ctrl),
        .elem_a     (s_tdata[15:0]),
        .elem_b     (s_tdata[31:16]),
        .sum        (sum),
        .overflowed (overflowed)
    );

    ed_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (acc_ctrl.clear),
        .radicand (sum),
        .busy     (root_busy),
        .root     (root)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = last_reg ? ST_START : ST_IDLE;
            end
            ST_START:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                // hold the root until it is done and the output register is free
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= s_tlast;
        end
        if (acc_ctrl.clear)
        begin
            sat_reg <= overflowed;
        end
        if (load_out)
        begin
            dist_reg    <= root;
            out_sat_reg <= sat_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24 - DIST_W){1'b0}}, dist_reg};
    assign m_tuser  = out_sat_reg;

endmodule

/* rtl/ed_checker.sv */
`timescale 1ns / 1ps
`include "euclidean_distance_macros.svh"

module ed_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // No result can be pending straight out of a reset cycle
    `ED_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "m_tvalid high during reset")

    // Two input transfers never come back to back
    `ED_ASSERT(a_busy_after_in, s_tvalid && s_tready |=> !s_tready, "input taken back to back")

    // A new result only appears at the end of a root computation
    `ED_ASSERT(a_result_after_busy, $rose(m_tvalid) |-> $past(!s_tready), "result out of sequence")

    // A saturated sum gives the all-ones distance
    `ED_ASSERT(a_sat_all_ones, m_tvalid && m_tuser |-> m_tdata[21:0] == 22'h3fffff, "bad saturated distance")

endmodule

bind euclidean_distance ed_checker u_ed_checker (.*);

/* tb/tb_euclidean_distance.sv */
`timescale 1ns / 1ps

module tb_euclidean_distance;
    import ed_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PAIRS = 1350;

    typedef struct {
        logic signed [ELEM_WIDTH-1:0] a;
        logic signed [ELEM_WIDTH-1:0] b;
        logic                         last;
        bit                           hold;  // wait for all pending distances first
    } pair_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              saturated;
    } dist_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [15:0] elem_a, [31:16] elem_b
    logic        s_tlast = 1'b0;  // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [21:0] distance, [23:22] zero
    logic        m_tuser;         // saturated

    pair_t pair_q[$];
    dist_t dist_q[$];

    // predictor state
    logic [SUM_W-1:0] sum_acc = '0;
    logic             sat_flag = 1'b0;

    pair_t cur_pair;
    bit    presenting = 1'b0;
    bit    drv_bursty = 1'b0;
    bit    ready_bursty = 1'b0;
    int    gap_left = 0;
    int    ready_stall = 0;
    int    cycle_cnt = 0;
    int    fail_cnt = 0;
    int    pairs_sent = 0;
    int    results_seen = 0;
    int    sat_seen = 0;

    euclidean_distance dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [DIST_W-1:0] floor_sqrt(input logic [SUM_W-1:0] x);
        logic [DIST_W-1:0] root;
        logic [DIST_W-1:0] trial;
        logic [SUM_W:0]    sq;
        root = '0;
        for (int i = DIST_W - 1; i >= 0; i--)
        begin
            trial = root | (DIST_W'(1) << i);
            sq = trial * trial;
            if (sq <= {1'b0, x})
                root = trial;
        end
        return root;
    endfunction

    // Add the squared difference of one pair; on the final pair queue the distance.
    function automatic void accumulate_pair(input pair_t p);
        logic signed [ELEM_WIDTH:0] diff;
        logic [ELEM_WIDTH:0]        mag;
        logic [SUM_W:0]             total;
        dist_t                      res;
        diff = {p.a[ELEM_WIDTH-1], p.a} - {p.b[ELEM_WIDTH-1], p.b};
        mag = diff[ELEM_WIDTH] ? -diff : diff;
        total = {1'b0, sum_acc} + mag * mag;
        if (total > {1'b0, SUM_MAX})
        begin
            sum_acc = SUM_MAX;
            sat_flag = 1'b1;
        end
        else
            sum_acc = total[SUM_W-1:0];
        if (p.last)
        begin
            res.distance = floor_sqrt(sum_acc);
            res.saturated = sat_flag;
            dist_q.push_back(res);
            sum_acc = '0;
            sat_flag = 1'b0;
        end
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [ELEM_WIDTH-1:0] pick_elem();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            2, 3:    return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_pair(input int a, input int b, input bit last, input bit hold = 1'b0);
        pair_t p;
        p.a = 16'(a);
        p.b = 16'(b);
        p.last = last;
        p.hold = hold;
        pair_q.push_back(p);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                accumulate_pair(cur_pair);
                pairs_sent++;
                presenting = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    drv_bursty = !drv_bursty;
                gap_left = (drv_bursty && $urandom_range(0, 2) == 0) ? gap_len() : 0;
            end
            if (!presenting)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pair_q.size() > 0 && !(pair_q[0].hold && dist_q.size() != 0))
                begin
                    cur_pair = pair_q.pop_front();
                    presenting = 1'b1;
                end
            end
            s_tvalid <= presenting;
            if (presenting)
            begin
                s_tdata <= {cur_pair.b, cur_pair.a};
                s_tlast <= cur_pair.last;
            end
            else
            begin
                s_tdata <= $urandom;
                s_tlast <= $urandom_range(0, 1);
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (dist_q.size() == 0)
                begin
                    $error("result transfer with no distance pending: distance %0d saturated %0d",
                           m_tdata[DIST_W-1:0], m_tuser);
                    fail_cnt++;
                end
                else
                begin
                    dist_t exp_res;
                    exp_res = dist_q.pop_front();
                    results_seen++;
                    if (exp_res.saturated)
                        sat_seen++;
                    if (m_tdata[DIST_W-1:0] !== exp_res.distance)
                    begin
                        $error("distance mismatch: expected %0d, actual %0d",
                               exp_res.distance, m_tdata[DIST_W-1:0]);
                        fail_cnt++;
                    end
                    if (m_tuser !== exp_res.saturated)
                    begin
                        $error("saturated mismatch: expected %0d, actual %0d",
                               exp_res.saturated, m_tuser);
                        fail_cnt++;
                    end
                end
            end
            if ($urandom_range(0, 199) == 0)
                ready_bursty = !ready_bursty;
            if (ready_stall > 0)
                ready_stall--;
            else if (ready_bursty && $urandom_range(0, 2) == 0)
                ready_stall = gap_len();
            m_tready <= (ready_stall == 0);
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d distances outstanding",
                 cycle_cnt, dist_q.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int len;
        int queued;

        // extremes and sign patterns, one-pair and short vectors
        add_pair(0, 0, 1);
        add_pair(32767, -32768, 1);
        add_pair(-32768, 32767, 1);
        add_pair(-32768, -32768, 1);
        add_pair(32767, 32767, 1);
        add_pair(1, 0, 1);
        add_pair(0, -1, 1);
        add_pair(-1, 1, 1);
        add_pair(256, 0, 0);
        add_pair(0, 256, 0);
        add_pair(-256, 0, 1);
        add_pair(16'h5555, 16'haaaa, 0);
        add_pair(16'haaaa, 16'h5555, 1);
        add_pair(32767, -32768, 0);
        add_pair(-32768, 32767, 0);
        add_pair(32767, -32768, 0);
        add_pair(-32768, 32767, 1);
        add_pair(100, 100, 0, 1'b1);
        add_pair(100, 100, 1);
        add_pair(3, 0, 1);

        queued = 0;
        while (queued < RANDOM_PAIRS)
        begin
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(100, 300);
                1, 2, 3: len = $urandom_range(9, 64);
                default: len = $urandom_range(1, 8);
            endcase
            for (int i = 0; i < len; i++)
            begin
                logic [ELEM_WIDTH-1:0] ea;
                logic [ELEM_WIDTH-1:0] eb;
                ea = pick_elem();
                eb = ($urandom_range(0, 9) == 0) ? ea + 16'($urandom_range(0, 2)) : pick_elem();
                add_pair(ea, eb, i == len - 1, i == 0 && $urandom_range(0, 29) == 0);
            end
            queued += len;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pair_q.size() != 0 || presenting || dist_q.size() != 0)
            @(posedge clk);
        // let any stray result show up
        repeat (40) @(posedge clk);

        $display("sent %0d pairs, checked %0d distances (%0d saturated), %0d cycles",
                 pairs_sent, results_seen, sat_seen, cycle_cnt);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ed_pkg.sv
rtl/ed_accum.sv
rtl/ed_sqrt.sv
rtl/euclidean_distance.sv
rtl/ed_checker.sv
tb/tb_euclidean_distance.sv
